// ----- sv/polynomial_remainder_mod_p_unit_assert.svh -----
// assertion macros shared by the polynomial remainder unit
`ifndef POLYNOMIAL_REMAINDER_MOD_P_UNIT_ASSERT_SVH
`define POLYNOMIAL_REMAINDER_MOD_P_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define PRPM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("prpm assertion failed");

// next-cycle implication, checked out of reset
`define PRPM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("prpm assertion failed");

`endif

// ----- sv/prpm_pkg.sv -----
// shared types and constants of the polynomial remainder unit
`timescale 1ns / 1ps

package prpm_pkg;

    localparam int COEFF_W    = 32;
    localparam int MAX_DEGREE = 63;
    localparam int DEPTH      = MAX_DEGREE + 1;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int BITCNT_W   = $clog2(COEFF_W);

    typedef logic [COEFF_W-1:0] t_coef;
    typedef logic [ADDR_W-1:0]  t_addr;

    // status of the modular multiplier
    typedef struct packed {
        logic busy;
        logic done;
    } t_mul_stat;

endpackage

// ----- sv/prpm_mulmod.sv -----
// bit-serial modular multiplier, one multiplier bit per cycle
`timescale 1ns / 1ps

module prpm_mulmod (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  prpm_pkg::t_coef  i_a,
    input  prpm_pkg::t_coef  i_b,
    input  prpm_pkg::t_coef  i_m,
    output prpm_pkg::t_coef  o_r,
    output prpm_pkg::t_mul_stat o_stat
);
    import prpm_pkg::*;

    t_coef               r_a, r_b, r_r;
    logic [BITCNT_W-1:0] r_cnt;
    logic                r_busy, r_done;

    logic [COEFF_W:0] w_dbl, w_dbl_red, w_sum, w_sum_red;

    // r = 2r + bit*a, reduced twice
    always_comb begin
        w_dbl     = {r_r, 1'b0};
        w_dbl_red = (w_dbl >= {1'b0, i_m}) ? w_dbl - {1'b0, i_m} : w_dbl;
        w_sum     = w_dbl_red + (r_b[COEFF_W-1] ? {1'b0, r_a} : '0);
        w_sum_red = (w_sum >= {1'b0, i_m}) ? w_sum - {1'b0, i_m} : w_sum;
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == BITCNT_W'(COEFF_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
            r_r <= '0;
        end else if (r_busy) begin
            r_b <= {r_b[COEFF_W-2:0], 1'b0};
            r_r <= w_sum_red[COEFF_W-1:0];
        end
    end

    assign o_r         = r_r;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

// ----- sv/prpm_store.sv -----
// coefficient memory with per-entry valid bits, unwritten entries read as zero
`timescale 1ns / 1ps

module prpm_store (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_clr,
    input  logic            i_we,
    input  prpm_pkg::t_addr i_waddr,
    input  prpm_pkg::t_coef i_wdata,
    input  prpm_pkg::t_addr i_raddr,
    output prpm_pkg::t_coef o_rdata
);
    import prpm_pkg::*;

    t_coef            r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    t_coef            r_rdata;
    logic             r_rvld;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (i_clr) begin
                r_vld <= '0;
            end else if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            r_rvld <= r_vld[i_raddr];
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rvld ? r_rdata : '0;

endmodule

// ----- sv/polynomial_remainder_mod_p_unit.sv -----
// top level: polynomial remainder over gf(p) with load, scan, inverse and division
//
//  channel   signals                                    direction
//  input     i_in_valid / o_in_stall + item fields       in
//  output    o_out_valid / i_out_stall + result fields   out
//  config    i_cfg_we / i_cfg_wdata (modulus)           in
//
// a loaded coefficient is reduced mod p in the bit-serial multiplier before the
// next item is accepted. a dividend item with load_last then scans the stores
// from the top for the leading terms, forms the inverse of the divisor lead with a
// square per exponent bit and a multiply per set bit, computes each quotient term
// and multiply-subtracts, (dx-dy+1)*(dy+1) of them, then emits the remainder terms.
// sync reset, stores read as zero; input stall high while busy, results wait on stall
`timescale 1ns / 1ps

module polynomial_remainder_mod_p_unit (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [31:0]              i_cfg_wdata,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic                     i_opcode,
    input  prpm_pkg::t_addr          i_degree_index,
    input  prpm_pkg::t_coef          i_coefficient,
    input  logic                     i_load_last,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output prpm_pkg::t_addr          o_result_degree,
    output prpm_pkg::t_coef          o_result_coefficient,
    output logic                     o_status,
    output logic                     o_result_last
);
    import prpm_pkg::*;

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_RED     = 5'd1;
    localparam logic [4:0] S_SCAN_RD = 5'd2;
    localparam logic [4:0] S_SCAN_CK = 5'd3;
    localparam logic [4:0] S_INV_M   = 5'd4;
    localparam logic [4:0] S_INV_MW  = 5'd5;
    localparam logic [4:0] S_INV_S   = 5'd6;
    localparam logic [4:0] S_INV_SW  = 5'd7;
    localparam logic [4:0] S_DV_RDT  = 5'd8;
    localparam logic [4:0] S_DV_C    = 5'd9;
    localparam logic [4:0] S_DV_CW   = 5'd10;
    localparam logic [4:0] S_DV_RDJ  = 5'd11;
    localparam logic [4:0] S_DV_MJ   = 5'd12;
    localparam logic [4:0] S_DV_MW   = 5'd13;
    localparam logic [4:0] S_EM_RD   = 5'd14;
    localparam logic [4:0] S_EM_LD   = 5'd15;
    localparam logic [4:0] S_EM_WT   = 5'd16;

    localparam logic OP_DIVISOR = 1'b0;
    localparam logic OP_DIVIDEND = 1'b1;

    logic [4:0] r_state, n_state;
    t_coef      r_modulus;
    logic       r_dsr_loading, n_dsr_loading;
    logic       r_dvd_loading, n_dvd_loading;
    logic       r_op, n_op;
    t_addr      r_idx, n_idx;
    logic       r_last, n_last;
    logic       r_scan_dvd, n_scan_dvd;
    t_addr      r_ptr, n_ptr;
    t_addr      r_dy, n_dy;
    t_addr      r_dx, n_dx;
    t_addr      r_i, n_i;
    t_addr      r_j, n_j;
    t_addr      r_k, n_k;
    t_coef      r_lead, n_lead;
    t_coef      r_inv, n_inv;
    t_coef      r_base, n_base;
    t_coef      r_exp, n_exp;
    logic [BITCNT_W-1:0] r_icnt, n_icnt;
    t_coef      r_c, n_c;
    t_coef      r_wv, n_wv;
    logic       r_out_valid, n_out_valid;
    t_addr      r_out_deg, n_out_deg;
    t_coef      r_out_coef, n_out_coef;
    logic       r_out_status, n_out_status;
    logic       r_out_last, n_out_last;

    t_coef      w_m;
    logic       w_accept;
    logic       w_mul_start;
    t_coef      w_mul_a, w_mul_b, w_mul_r;
    t_mul_stat  w_mul_stat;
    logic       w_dsr_clr, w_dsr_we, w_dvd_clr, w_dvd_we;
    t_addr      w_dsr_raddr, w_dvd_raddr, w_dvd_waddr;
    t_coef      w_dsr_rdata, w_dvd_rdata, w_dvd_wdata, w_scan_data, w_sub;
    logic [COEFF_W:0] w_sub_wide;

    // effective modulus, 0 and 1 act as 2
    assign w_m      = (r_modulus < t_coef'(2)) ? t_coef'(2) : r_modulus;
    assign w_accept = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);

    // modular subtract of the scaled divisor term
    assign w_sub_wide = {1'b0, r_wv} + {1'b0, w_m} - {1'b0, w_mul_r};
    assign w_sub = (r_wv >= w_mul_r) ? (r_wv - w_mul_r) : w_sub_wide[COEFF_W-1:0];
    assign w_scan_data = r_scan_dvd ? w_dvd_rdata : w_dsr_rdata;

    // shared multiplier operands
    always_comb begin
        w_mul_start = 1'b0;
        w_mul_a     = r_inv;
        w_mul_b     = r_base;
        case (r_state)
            S_IDLE: begin
                w_mul_start = w_accept;
                w_mul_a     = t_coef'(1);
                w_mul_b     = i_coefficient;
            end
            S_INV_M: begin
                w_mul_start = r_exp[0];
                w_mul_a     = r_inv;
                w_mul_b     = r_base;
            end
            S_INV_S: begin
                w_mul_start = 1'b1;
                w_mul_a     = r_base;
                w_mul_b     = r_base;
            end
            S_DV_C: begin
                w_mul_start = 1'b1;
                w_mul_a     = w_dvd_rdata;
                w_mul_b     = r_inv;
            end
            S_DV_MJ: begin
                w_mul_start = 1'b1;
                w_mul_a     = w_dsr_rdata;
                w_mul_b     = r_c;
            end
            default: begin
                w_mul_start = 1'b0;
            end
        endcase
    end

    // memory ports
    always_comb begin
        w_dsr_clr   = w_accept && (i_opcode == OP_DIVISOR) && !r_dsr_loading;
        w_dvd_clr   = w_accept && (i_opcode == OP_DIVIDEND) && !r_dvd_loading;
        w_dsr_we    = (r_state == S_RED) && w_mul_stat.done && (r_op == OP_DIVISOR);
        w_dvd_we    = 1'b0;
        w_dvd_waddr = r_idx;
        w_dvd_wdata = w_mul_r;
        w_dsr_raddr = r_ptr;
        w_dvd_raddr = r_ptr;
        case (r_state)
            S_RED: begin
                w_dvd_we = w_mul_stat.done && (r_op == OP_DIVIDEND);
            end
            S_DV_RDT: begin
                w_dvd_raddr = r_i;
            end
            S_DV_RDJ: begin
                w_dvd_raddr = r_i - r_j;
                w_dsr_raddr = r_dy - r_j;
            end
            S_DV_MW: begin
                w_dvd_we    = w_mul_stat.done;
                w_dvd_waddr = r_i - r_j;
                w_dvd_wdata = w_sub;
            end
            S_EM_RD: begin
                w_dvd_raddr = r_k;
            end
            default: begin
                w_dvd_we = 1'b0;
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state       = r_state;
        n_dsr_loading = r_dsr_loading;
        n_dvd_loading = r_dvd_loading;
        n_op          = r_op;
        n_idx         = r_idx;
        n_last        = r_last;
        n_scan_dvd    = r_scan_dvd;
        n_ptr         = r_ptr;
        n_dy          = r_dy;
        n_dx          = r_dx;
        n_i           = r_i;
        n_j           = r_j;
        n_k           = r_k;
        n_lead        = r_lead;
        n_inv         = r_inv;
        n_base        = r_base;
        n_exp         = r_exp;
        n_icnt        = r_icnt;
        n_c           = r_c;
        n_wv          = r_wv;
        n_out_valid   = r_out_valid;
        n_out_deg     = r_out_deg;
        n_out_coef    = r_out_coef;
        n_out_status  = r_out_status;
        n_out_last    = r_out_last;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_op   = i_opcode;
                    n_idx  = i_degree_index;
                    n_last = i_load_last;
                    if (i_opcode == OP_DIVIDEND) begin
                        n_dvd_loading = !i_load_last;
                    end else begin
                        n_dsr_loading = !i_load_last;
                    end
                    n_state = S_RED;
                end
            end
            S_RED: begin
                if (w_mul_stat.done) begin
                    if (r_op == OP_DIVIDEND && r_last) begin
                        n_scan_dvd = 1'b0;
                        n_ptr      = t_addr'(MAX_DEGREE);
                        n_state    = S_SCAN_RD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_SCAN_RD: begin
                n_state = S_SCAN_CK;
            end
            S_SCAN_CK: begin
                if (w_scan_data != '0 || r_ptr == '0) begin
                    if (!r_scan_dvd) begin
                        n_dy   = r_ptr;
                        n_lead = w_scan_data;
                        if (w_scan_data == '0 || r_ptr == '0) begin
                            // zero divisor or constant divisor: one result
                            n_out_valid  = 1'b1;
                            n_out_deg    = '0;
                            n_out_coef   = '0;
                            n_out_status = (w_scan_data == '0);
                            n_out_last   = 1'b1;
                            n_state      = S_EM_WT;
                        end else begin
                            n_scan_dvd = 1'b1;
                            n_ptr      = t_addr'(MAX_DEGREE);
                            n_state    = S_SCAN_RD;
                        end
                    end else begin
                        n_dx    = r_ptr;
                        n_inv   = t_coef'(1);
                        n_base  = r_lead;
                        n_exp   = w_m - t_coef'(2);
                        n_icnt  = '0;
                        n_state = S_INV_M;
                    end
                end else begin
                    n_ptr   = r_ptr - 1'b1;
                    n_state = S_SCAN_RD;
                end
            end
            // inverse as lead^(p-2), exponent bits lsb first
            S_INV_M: begin
                n_state = r_exp[0] ? S_INV_MW : S_INV_S;
            end
            S_INV_MW: begin
                if (w_mul_stat.done) begin
                    n_inv   = w_mul_r;
                    n_state = S_INV_S;
                end
            end
            S_INV_S: begin
                n_state = S_INV_SW;
            end
            S_INV_SW: begin
                if (w_mul_stat.done) begin
                    n_base = w_mul_r;
                    n_exp  = r_exp >> 1;
                    n_icnt = r_icnt + 1'b1;
                    if (r_icnt == BITCNT_W'(COEFF_W - 1)) begin
                        if (r_dx < r_dy) begin
                            n_k     = '0;
                            n_state = S_EM_RD;
                        end else begin
                            n_i     = r_dx;
                            n_state = S_DV_RDT;
                        end
                    end else begin
                        n_state = S_INV_M;
                    end
                end
            end
            // long division, in place on the dividend store
            S_DV_RDT: begin
                n_state = S_DV_C;
            end
            S_DV_C: begin
                n_state = S_DV_CW;
            end
            S_DV_CW: begin
                if (w_mul_stat.done) begin
                    n_c     = w_mul_r;
                    n_j     = '0;
                    n_state = S_DV_RDJ;
                end
            end
            S_DV_RDJ: begin
                n_state = S_DV_MJ;
            end
            S_DV_MJ: begin
                n_wv    = w_dvd_rdata;
                n_state = S_DV_MW;
            end
            S_DV_MW: begin
                if (w_mul_stat.done) begin
                    if (r_j == r_dy) begin
                        if (r_i == r_dy) begin
                            n_k     = '0;
                            n_state = S_EM_RD;
                        end else begin
                            n_i     = r_i - 1'b1;
                            n_state = S_DV_RDT;
                        end
                    end else begin
                        n_j     = r_j + 1'b1;
                        n_state = S_DV_RDJ;
                    end
                end
            end
            // remainder coefficients, degree 0 upward
            S_EM_RD: begin
                n_state = S_EM_LD;
            end
            S_EM_LD: begin
                n_out_valid  = 1'b1;
                n_out_deg    = r_k;
                n_out_coef   = w_dvd_rdata;
                n_out_status = 1'b0;
                n_out_last   = (r_k == r_dy - 1'b1);
                n_state      = S_EM_WT;
            end
            S_EM_WT: begin
                if (!i_out_stall) begin
                    n_out_valid = 1'b0;
                    if (r_out_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_k     = r_k + 1'b1;
                        n_state = S_EM_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_modulus     <= t_coef'(2);
            r_dsr_loading <= 1'b0;
            r_dvd_loading <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_dsr_loading <= n_dsr_loading;
            r_dvd_loading <= n_dvd_loading;
            r_out_valid   <= n_out_valid;
            if (i_cfg_we) begin
                r_modulus <= i_cfg_wdata;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_idx        <= n_idx;
        r_last       <= n_last;
        r_scan_dvd   <= n_scan_dvd;
        r_ptr        <= n_ptr;
        r_dy         <= n_dy;
        r_dx         <= n_dx;
        r_i          <= n_i;
        r_j          <= n_j;
        r_k          <= n_k;
        r_lead       <= n_lead;
        r_inv        <= n_inv;
        r_base       <= n_base;
        r_exp        <= n_exp;
        r_icnt       <= n_icnt;
        r_c          <= n_c;
        r_wv         <= n_wv;
        r_out_deg    <= n_out_deg;
        r_out_coef   <= n_out_coef;
        r_out_status <= n_out_status;
        r_out_last   <= n_out_last;
    end

    prpm_mulmod u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .i_m     (w_m),
        .o_r     (w_mul_r),
        .o_stat  (w_mul_stat)
    );

    prpm_store u_dsr_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (w_dsr_clr),
        .i_we    (w_dsr_we),
        .i_waddr (r_idx),
        .i_wdata (w_mul_r),
        .i_raddr (w_dsr_raddr),
        .o_rdata (w_dsr_rdata)
    );

    prpm_store u_dvd_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (w_dvd_clr),
        .i_we    (w_dvd_we),
        .i_waddr (w_dvd_waddr),
        .i_wdata (w_dvd_wdata),
        .i_raddr (w_dvd_raddr),
        .o_rdata (w_dvd_rdata)
    );

    assign o_out_valid          = r_out_valid;
    assign o_result_degree      = r_out_deg;
    assign o_result_coefficient = r_out_coef;
    assign o_status             = r_out_status;
    assign o_result_last        = r_out_last;

    `include "polynomial_remainder_mod_p_unit_assert.svh"

    // an accepted transaction blocks the next one
    `PRPM_ASSERT_NXT(a_accept_stalls, i_clk, i_rst_n, w_accept, o_in_stall)
    // results only show while emitting
    `PRPM_ASSERT_IMP(a_out_in_emit, i_clk, i_rst_n, r_out_valid, r_state == S_EM_WT)
    // multiplier never restarted mid-operation
    `PRPM_ASSERT_IMP(a_mul_free, i_clk, i_rst_n, w_mul_start, !w_mul_stat.busy)

endmodule

// ----- test/tb_top.sv -----
// self-checking testbench of the polynomial remainder unit over gf(p)
`timescale 1ns / 1ps

module tb_top;

    import prpm_pkg::*;

    localparam logic OP_DIVISOR  = 1'b0;
    localparam logic OP_DIVIDEND = 1'b1;
    localparam logic ST_OK       = 1'b0;
    localparam logic ST_ZERO_DIV = 1'b1;
    localparam int   IDLE_LIMIT  = 100000;
    localparam int   LONG_HOLD   = 400;
    localparam int   SETTLE      = 150;

    typedef struct packed {
        t_addr degree;
        t_coef coef;
        logic  status;
        logic  last;
    } t_rem;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [31:0] cfg_wdata;
    logic        in_valid;
    logic        in_stall;
    logic        opcode;
    t_addr       degree_index;
    t_coef       coefficient;
    logic        load_last;
    logic        out_valid;
    logic        out_stall;
    t_addr       res_degree;
    t_coef       res_coef;
    logic        res_status;
    logic        res_last;

    // golden copy of the block state
    logic [31:0] divisor_mem [DEPTH];
    logic [31:0] dividend_mem [DEPTH];
    bit          divisor_busy;
    bit          dividend_busy;
    logic [31:0] modulus_reg;

    t_rem        pending_rem [$];
    int          fail_count;
    int          idle_cycles;
    bit          quiet;
    bit          hold_req;

    polynomial_remainder_mod_p_unit u_dut (
        .i_clk                (clk),
        .i_rst_n              (rst_n),
        .i_cfg_we             (cfg_we),
        .i_cfg_wdata          (cfg_wdata),
        .i_in_valid           (in_valid),
        .o_in_stall           (in_stall),
        .i_opcode             (opcode),
        .i_degree_index       (degree_index),
        .i_coefficient        (coefficient),
        .i_load_last          (load_last),
        .o_out_valid          (out_valid),
        .i_out_stall          (out_stall),
        .o_result_degree      (res_degree),
        .o_result_coefficient (res_coef),
        .o_status             (res_status),
        .o_result_last        (res_last)
    );

    // clock
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint unsigned field_mod();
        return (modulus_reg < 2) ? 64'd2 : {32'd0, modulus_reg};
    endfunction

    function automatic int top_deg(input logic [31:0] mem [DEPTH]);
        for (int i = MAX_DEGREE; i > 0; i--) begin
            if (mem[i] != 0) return i;
        end
        return 0;
    endfunction

    // a^(m-2) mod m, the field inverse when m is prime
    function automatic longint unsigned pow_inverse(input longint unsigned a,
                                                    input longint unsigned m);
        longint unsigned e, r, b;
        e = m - 2;
        r = 1 % m;
        b = a;
        while (e != 0) begin
            if (e[0]) r = (r * b) % m;
            b = (b * b) % m;
            e = e >> 1;
        end
        return r;
    endfunction

    // update the golden state for one accepted transaction, queue remainders
    task automatic predict_remainder(input logic op, input t_addr idx, input t_coef c,
                                     input logic last);
        longint unsigned m, q, lead_inv, prod;
        longint unsigned work [DEPTH];
        int dx, dy;
        m = field_mod();
        if (op == OP_DIVIDEND) begin
            if (!dividend_busy) begin
                foreach (dividend_mem[i]) dividend_mem[i] = '0;
                dividend_busy = 1'b1;
            end
            dividend_mem[idx] = 32'(c % m);
            if (last) dividend_busy = 1'b0;
        end else begin
            if (!divisor_busy) begin
                foreach (divisor_mem[i]) divisor_mem[i] = '0;
                divisor_busy = 1'b1;
            end
            divisor_mem[idx] = 32'(c % m);
            if (last) divisor_busy = 1'b0;
        end
        if (!(op == OP_DIVIDEND && last)) return;

        dy = top_deg(divisor_mem);
        if (divisor_mem[dy] == 0) begin
            pending_rem.push_back('{degree: '0, coef: '0, status: ST_ZERO_DIV, last: 1'b1});
            return;
        end
        if (dy == 0) begin
            pending_rem.push_back('{degree: '0, coef: '0, status: ST_OK, last: 1'b1});
            return;
        end
        foreach (work[i]) work[i] = dividend_mem[i];
        dx = top_deg(dividend_mem);
        lead_inv = pow_inverse(divisor_mem[dy], m);
        for (int i = dx; i >= dy; i--) begin
            q = (work[i] * lead_inv) % m;
            for (int j = 0; j <= dy; j++) begin
                prod = (longint'(divisor_mem[dy - j]) * q) % m;
                work[i - j] = (work[i - j] >= prod) ? work[i - j] - prod
                                                    : work[i - j] + (m - prod);
            end
        end
        for (int i = 0; i < dy; i++) begin
            pending_rem.push_back('{degree: t_addr'(i), coef: t_coef'(work[i]),
                                    status: ST_OK, last: (i + 1 == dy)});
        end
    endtask

    // send one coefficient transaction and wait until it is taken
    task automatic send_coef(input logic op, input int idx, input t_coef c,
                             input logic last);
        int gap;
        @(negedge clk);
        in_valid     <= 1'b1;
        opcode       <= op;
        degree_index <= t_addr'(idx);
        coefficient  <= c;
        load_last    <= last;
        forever begin
            @(posedge clk);
            if (!in_stall) break;
        end
        predict_remainder(op, t_addr'(idx), c, last);
        // random sender gap
        if (!quiet && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 4);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic sender_idle();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        sender_idle();
        while (pending_rem.size() != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // modulus write, only with the block idle
    task automatic write_modulus(input logic [31:0] value);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        modulus_reg = value;
    endtask

    function automatic t_coef rand_coef(input bit nonzero);
        longint unsigned m;
        m = field_mod();
        if (nonzero) return t_coef'(1 + ($urandom % (m - 1)));
        if ($urandom_range(0, 15) == 0) return $urandom;
        return t_coef'($urandom % m);
    endfunction

    // full polynomial load of one kind, ascending powers
    task automatic load_poly(input logic op, input int deg);
        for (int i = 0; i <= deg; i++) begin
            send_coef(op, i, rand_coef(i == deg && $urandom_range(0, 7) != 0), i == deg);
        end
    endtask

    task automatic run_division(input int dy, input int dx);
        load_poly(OP_DIVISOR, dy);
        load_poly(OP_DIVIDEND, dx);
    endtask

    // directed corners
    task automatic test_reset_state();
        // dividend with nothing loaded: zero divisor
        send_coef(OP_DIVIDEND, 63, 32'hFFFF_FFFF, 1'b1);
        send_coef(OP_DIVISOR, 0, 32'h0000_0001, 1'b1);
        send_coef(OP_DIVIDEND, 0, 32'h0000_0000, 1'b1);
    endtask

    task automatic test_directed();
        write_modulus(32'd7);
        // degree 2 divisor, degree 5 dividend
        send_coef(OP_DIVISOR, 2, 32'd3, 1'b0);
        send_coef(OP_DIVISOR, 0, 32'd5, 1'b1);
        send_coef(OP_DIVIDEND, 5, 32'd6, 1'b0);
        send_coef(OP_DIVIDEND, 1, 32'd4, 1'b1);
        // dividend below divisor degree
        send_coef(OP_DIVIDEND, 1, 32'hFFFF_FFFF, 1'b1);
        // divisor of degree 63 and a dividend at 63
        send_coef(OP_DIVISOR, 63, 32'd2, 1'b0);
        send_coef(OP_DIVISOR, 0, 32'd1, 1'b1);
        send_coef(OP_DIVIDEND, 63, 32'd1, 1'b0);
        send_coef(OP_DIVIDEND, 0, 32'd3, 1'b1);
        // divisor still loading while a division starts
        send_coef(OP_DIVISOR, 1, 32'd4, 1'b0);
        send_coef(OP_DIVIDEND, 3, 32'd2, 1'b1);
        send_coef(OP_DIVISOR, 2, 32'd1, 1'b1);
        send_coef(OP_DIVIDEND, 4, 32'd5, 1'b1);
        // constant divisor
        send_coef(OP_DIVISOR, 0, 32'd3, 1'b1);
        send_coef(OP_DIVIDEND, 2, 32'd1, 1'b1);
        // modulus below two acts as two
        write_modulus(32'd0);
        send_coef(OP_DIVISOR, 1, 32'd3, 1'b1);
        send_coef(OP_DIVIDEND, 2, 32'd1, 1'b1);
        write_modulus(32'd1);
        send_coef(OP_DIVIDEND, 3, 32'd1, 1'b1);
        // non-prime moduli
        write_modulus(32'd10);
        send_coef(OP_DIVISOR, 1, 32'd4, 1'b1);
        send_coef(OP_DIVIDEND, 3, 32'd9, 1'b1);
        write_modulus(32'hFFFF_FFFF);
        send_coef(OP_DIVISOR, 2, 32'hFFFF_FFFE, 1'b1);
        send_coef(OP_DIVIDEND, 4, 32'hFFFF_FFFF, 1'b1);
    endtask

    task automatic test_random();
        logic [31:0] moduli [7] = '{32'd3, 32'd65537, 32'd4294967291, 32'd257,
                                    32'd2, 32'hFFFF_FFFF, 32'd0};
        foreach (moduli[k]) begin
            write_modulus(k == 6 ? $urandom : moduli[k]);
            repeat (1) begin
                if ($urandom_range(0, 5) == 0) begin
                    // noise and broken loads
                    repeat (3) send_coef(1'($urandom_range(0, 1)), $urandom_range(0, 63),
                                         $urandom, 1'($urandom_range(0, 1)));
                end else if ($urandom_range(0, 9) == 0) begin
                    run_division($urandom_range(0, 1), $urandom_range(0, 5));
                end else begin
                    run_division($urandom_range(1, 5), $urandom_range(0, 9));
                end
            end
        end
        // one large-degree dividend
        send_coef(OP_DIVISOR, 2, rand_coef(1'b1), 1'b1);
        send_coef(OP_DIVIDEND, 40, rand_coef(1'b1), 1'b1);
    endtask

    task automatic test_backpressure();
        write_modulus(32'd4294967291);
        hold_req = 1'b1;
        run_division(8, 10);
        run_division(3, 6);
        // pause until every remainder is out, then resume
        wait_drained();
        run_division(4, 8);
    endtask

    task automatic test_quiet_tail();
        wait_drained();
        quiet = 1'b1;
        run_division(3, 7);
        run_division(2, 5);
    endtask

    // receiver stall bursts and the long hold once a result is waiting
    initial begin
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req && out_valid) begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
                hold_req = 1'b0;
                out_stall <= 1'b0;
            end else if (!quiet && rst_n && $urandom_range(0, 3) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 4)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // result check against the oldest expected remainder
    always @(posedge clk) begin
        t_rem exp_rem;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_rem.size() == 0) begin
                $error("unexpected result transaction, degree %0d", res_degree);
                fail_count++;
            end else begin
                exp_rem = pending_rem.pop_front();
                if (res_degree !== exp_rem.degree) begin
                    $error("result_degree expected %0d actual %0d", exp_rem.degree,
                           res_degree);
                    fail_count++;
                end
                if (res_coef !== exp_rem.coef) begin
                    $error("result_coefficient expected %0d actual %0d", exp_rem.coef,
                           res_coef);
                    fail_count++;
                end
                if (res_status !== exp_rem.status) begin
                    $error("status expected %0d actual %0d", exp_rem.status, res_status);
                    fail_count++;
                end
                if (res_last !== exp_rem.last) begin
                    $error("result_last expected %0d actual %0d", exp_rem.last, res_last);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("polynomial_remainder_mod_p_unit test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // main sequence
    initial begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        in_valid      = 1'b0;
        opcode        = OP_DIVISOR;
        degree_index  = '0;
        coefficient   = '0;
        load_last     = 1'b0;
        fail_count    = 0;
        idle_cycles   = 0;
        quiet         = 1'b0;
        hold_req      = 1'b0;
        divisor_busy  = 1'b0;
        dividend_busy = 1'b0;
        modulus_reg   = 32'd2;
        foreach (divisor_mem[i]) divisor_mem[i] = '0;
        foreach (dividend_mem[i]) dividend_mem[i] = '0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        test_reset_state();
        test_directed();
        test_random();
        test_backpressure();
        test_quiet_tail();
        wait_drained();

        if (fail_count == 0) begin
            $display("polynomial_remainder_mod_p_unit test passed");
        end else begin
            $display("polynomial_remainder_mod_p_unit test failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+sv
sv/prpm_pkg.sv
sv/prpm_mulmod.sv
sv/prpm_store.sv
sv/polynomial_remainder_mod_p_unit.sv
test/tb_top.sv
